// ===== src/esh_pkg.sv =====
`default_nettype none

package esh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] FnvBasis = 32'd2166136261;
  localparam logic [HashW-1:0] FnvPrime = 32'd16777619;

  typedef struct packed {
    logic acc;
    logic rec_wr;
    logic chk_start;
    logic scan_rd;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic cmp_done;
    logic hit;
  } sts_t;

  function automatic logic [HashW-1:0] fold_byte(input logic [HashW-1:0] h,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] x;
    x = h ^ {{(HashW-ByteW){1'b0}}, b};
    return x * FnvPrime;
  endfunction

endpackage

`default_nettype wire

// ===== src/esh_ram.sv =====
`default_nettype none

module esh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                           wdata_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/esh_datapath.sv =====
`default_nettype none

module esh_datapath #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  esh_pkg::cmd_t          cmd_i,
  output esh_pkg::sts_t                sts_o,
  input  wire  [esh_pkg::ByteW-1:0]    data_byte_i,
  input  wire                          byte_valid_i,
  input  wire                          last_i,
  output logic                         is_echo_o,
  output logic [esh_pkg::HashW-1:0]    msg_hash_o
);

  import esh_pkg::*;

  localparam int unsigned AddrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(RING_DEPTH - 1);

  logic [HashW-1:0] hash_q, hash_d, h_next;
  logic [HashW-1:0] tgt_q;
  logic [AddrW-1:0] slot_q, slot_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] rd_addr_q;
  logic             rd_vld_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic [HashW-1:0] ram_rd, entry;
  logic             hit;
  logic             echo_q;
  logic [HashW-1:0] out_hash_q;

  assign h_next = byte_valid_i ? fold_byte(hash_q, data_byte_i) : hash_q;

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.acc) begin
      hash_d = last_i ? FnvBasis : h_next;
    end
  end

  assign slot_d = (slot_q == LastAddr) ? '0 : slot_q + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.chk_start) begin
      cnt_d = '0;
    end else if (cmd_i.scan_rd && cnt_q != LastAddr) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  esh_ram #(
    .WIDTH(HashW),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.rec_wr),
    .waddr_i(slot_q),
    .wdata_i(h_next),
    .raddr_i(cnt_q),
    .rdata_o(ram_rd)
  );

  // a slot never written or already cleared reads as zero
  assign entry = valid_q[rd_addr_q] ? ram_rd : '0;
  assign hit   = rd_vld_q && (entry == tgt_q);

  assign sts_o.hit      = hit;
  assign sts_o.cmp_done = rd_vld_q && (hit || rd_addr_q == LastAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= FnvBasis;
      slot_q    <= '0;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
    end else begin
      hash_q    <= hash_d;
      cnt_q     <= cnt_d;
      rd_addr_q <= cnt_q;
      rd_vld_q  <= cmd_i.scan_rd;
      if (cmd_i.rec_wr) begin
        slot_q          <= slot_d;
        valid_q[slot_q] <= 1'b1;
      end
      if (cmd_i.fin && hit) begin
        valid_q[rd_addr_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk_start) begin
      tgt_q <= h_next;
    end
    if (cmd_i.rec_wr) begin
      echo_q     <= 1'b0;
      out_hash_q <= h_next;
    end else if (cmd_i.fin) begin
      echo_q     <= hit;
      out_hash_q <= tgt_q;
    end
  end

  assign is_echo_o  = echo_q;
  assign msg_hash_o = out_hash_q;

endmodule

`default_nettype wire

// ===== src/esh_ctrl.sv =====
`default_nettype none

module esh_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  input  wire                 s_tlast_i,
  input  wire                 s_req_type_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  wire                 m_tready_i,
  output esh_pkg::cmd_t       cmd_o,
  input  wire  esh_pkg::sts_t sts_i
);

  import esh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   m_tvalid_q, m_tvalid_d;
  logic   acc;

  // a last item needs the output register free by the next edge
  assign s_tready_o = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready_i || !s_tlast_i);
  assign acc        = s_tvalid_i && s_tready_o;

  assign cmd_o.acc       = acc;
  assign cmd_o.rec_wr    = acc && s_tlast_i && !s_req_type_i;
  assign cmd_o.chk_start = acc && s_tlast_i && s_req_type_i;
  assign cmd_o.scan_rd   = (state_q == ST_SCAN);
  assign cmd_o.fin       = (state_q == ST_SCAN) && sts_i.cmp_done;

  assign m_tvalid_d = cmd_o.rec_wr || cmd_o.fin || (m_tvalid_q && !m_tready_i);
  assign m_tvalid_o = m_tvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.chk_start) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmd_o.fin) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_scan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !s_tready_o)
    else $error("input taken during ring scan");

  a_check_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.chk_start |=> (state_q == ST_SCAN) && !m_tvalid_q)
    else $error("check transaction did not start a scan");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rec_wr || cmd_o.fin) |=> m_tvalid_q)
    else $error("result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && !m_tready_i) |-> !(cmd_o.rec_wr || cmd_o.fin))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== src/echo_suppression_hash_ring_unit.sv =====
// channel  | dir | tdata                          | tuser        | tlast
// s_axis   | in  | [7:0] data_byte, [8] byte_valid | req_type     | last
// m_axis   | out | [31:0] msg_hash                | is_echo      | -
//
// a byte that does not end a message is folded into the running hash; s_axis stays ready for it while idle
// a record-mode last byte writes its hash into the ring, its result is registered for the next edge
// a check-mode last byte starts a scan of the ring through its single read port,
// one slot per cycle, until a match or the last slot is reached; the result is then shown
// after reset every ring slot is flagged empty and reads as zero, no clearing pass
// a last byte waits while an earlier result is held by m_axis_tready_i low
`default_nettype none

module echo_suppression_hash_ring_unit #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [7:0] data_byte, [8] byte_valid, zero fill
  input  wire         s_axis_tuser_i,   // [0] req_type
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] msg_hash
  output logic        m_axis_tuser_o    // [0] is_echo
);

  import esh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  esh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tlast_i   (s_axis_tlast_i),
    .s_req_type_i(s_axis_tuser_i),
    .s_tready_o  (s_axis_tready_o),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  esh_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (s_axis_tdata_i[7:0]),
    .byte_valid_i(s_axis_tdata_i[8]),
    .last_i      (s_axis_tlast_i),
    .is_echo_o   (m_axis_tuser_o),
    .msg_hash_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
